### src/mbrot_pkg.sv
// package: shared constants and register codes for the escape-time pixel engine
package mbrot_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 28;
	localparam int INDEX_WIDTH_DEF = 12;

	localparam int ITER_GUARD = 4;

	localparam int APB_NARROW = 32;
	localparam int APB_WIDE   = 64;

	localparam int REG_IDX_WIDTH = 3;

	typedef enum logic [REG_IDX_WIDTH-1:0] {
		REG_LIMIT    = 3'd0,
		REG_X_ORIGIN = 3'd1,
		REG_Y_ORIGIN = 3'd2,
		REG_STEP_X   = 3'd3,
		REG_STEP_Y   = 3'd4
	} reg_idx_t;

	localparam int LIMIT_RST    = 255;
	localparam int X_ORIGIN_RST = -477839688;
	localparam int Y_ORIGIN_RST = 257966588;
	localparam int STEP_X_RST   = 335544;
	localparam int STEP_Y_RST   = 336279;

	localparam int RING_STAGES = 5;
	localparam int TAG_WIDTH   = 3;

	localparam int INTENSITY_WIDTH = 8;
	localparam int INTENSITY_MAX   = 255;
	localparam int DIV_STEPS       = 8;
	localparam int DCNT_WIDTH      = 4;

endpackage

### src/mandelbrot_escape_time.sv
// top level: pipelined mandelbrot escape-time pixel engine with apb configuration
//
//  channel  | direction | handshake                   | payload
//  pixel    | in        | pixel_valid / pixel_stall   | column, row
//  result   | out       | result_valid / result_stall | iterations, intensity
//  config   | in        | apb psel/penable/pready     | paddr, pwdata, prdata
//
// a request forms c in entry stages s1 and s2, then circulates in a five-stage
// iteration loop: one pass per update, one more pass for the last
// escape test, then 8 passes for the intensity division, then the output register.
// up to five requests share the loop; results leave in request order.
// reset clears valid bits and tags and loads the default limit and window; no clearing pass.
// the loop never stops: result_stall only holds the output register and a
// finished request keeps circulating; pixel_stall rises when both entry
// stages hold requests and no loop slot opens.
module mandelbrot_escape_time #(
	parameter int COORD_WIDTH = mbrot_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = mbrot_pkg::FRAC_BITS_DEF,
	parameter int INDEX_WIDTH = mbrot_pkg::INDEX_WIDTH_DEF,
	localparam int PDATA_W = (COORD_WIDTH > mbrot_pkg::APB_NARROW) ?
		mbrot_pkg::APB_WIDE : mbrot_pkg::APB_NARROW,
	localparam int ADDR_LSB = $clog2(PDATA_W / 8),
	localparam int PADDR_W  = ADDR_LSB + mbrot_pkg::REG_IDX_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [PADDR_W-1:0]                    paddr,
	input  logic [PDATA_W-1:0]                    pwdata,
	output logic [PDATA_W-1:0]                    prdata,
	output logic                                  pready,
	input  logic                                  pixel_valid,
	output logic                                  pixel_stall,
	input  logic [INDEX_WIDTH-1:0]                column,
	input  logic [INDEX_WIDTH-1:0]                row,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic [INDEX_WIDTH-1:0]                iterations,
	output logic [mbrot_pkg::INTENSITY_WIDTH-1:0] intensity
);
	import mbrot_pkg::*;

	localparam int ITW  = COORD_WIDTH + ITER_GUARD;
	localparam int H    = ITW / 2;
	localparam int HW   = ITW - H;
	localparam int PW   = 2 * ITW;
	localparam int SW   = PW + 1;
	localparam int CSW  = INDEX_WIDTH + COORD_WIDTH + 1;
	localparam int PRW  = INDEX_WIDTH + COORD_WIDTH - 1;
	localparam int REM_W = INDEX_WIDTH + INTENSITY_WIDTH;
	localparam int DSW  = REM_W + 1;
	localparam logic [PW-1:0] THR = PW'(1) << (2 * FRAC_BITS + 2);

	typedef struct packed {
		logic                       done;
		logic [TAG_WIDTH-1:0]       tag;
		logic [INDEX_WIDTH-1:0]     cnt;
		logic [ITW-1:0]             x;
		logic [ITW-1:0]             y;
		logic [COORD_WIDTH-1:0]     a;
		logic [COORD_WIDTH-1:0]     b;
		logic [REM_W-1:0]           rem;
		logic [INTENSITY_WIDTH-1:0] quo;
		logic [DCNT_WIDTH-1:0]      dcnt;
	} ctx_t;

	function automatic logic [ITW-1:0] sat_iter(input logic [SW-1:0] v);
		logic [SW-ITW:0] upper;
		upper = v[SW-1:ITW-1];
		if (&upper || ~|upper) begin
			return v[ITW-1:0];
		end
		return {v[SW-1], {(ITW-1){~v[SW-1]}}};
	endfunction

	function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic [CSW-1:0] v);
		logic [CSW-COORD_WIDTH:0] upper;
		upper = v[CSW-1:COORD_WIDTH-1];
		if (&upper || ~|upper) begin
			return v[COORD_WIDTH-1:0];
		end
		return {v[CSW-1], {(COORD_WIDTH-1){~v[CSW-1]}}};
	endfunction

	// configuration registers
	logic [INDEX_WIDTH-1:0] limit_q;
	logic [COORD_WIDTH-1:0] x_origin_q;
	logic [COORD_WIDTH-1:0] y_origin_q;
	logic [COORD_WIDTH-2:0] step_x_q;
	logic [COORD_WIDTH-2:0] step_y_q;
	reg_idx_t               reg_idx;
	logic                   cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:ADDR_LSB]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= INDEX_WIDTH'(LIMIT_RST);
			x_origin_q <= COORD_WIDTH'(X_ORIGIN_RST);
			y_origin_q <= COORD_WIDTH'(Y_ORIGIN_RST);
			step_x_q   <= (COORD_WIDTH-1)'(STEP_X_RST);
			step_y_q   <= (COORD_WIDTH-1)'(STEP_Y_RST);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_LIMIT:    limit_q    <= pwdata[INDEX_WIDTH-1:0];
				REG_X_ORIGIN: x_origin_q <= pwdata[COORD_WIDTH-1:0];
				REG_Y_ORIGIN: y_origin_q <= pwdata[COORD_WIDTH-1:0];
				REG_STEP_X:   step_x_q   <= pwdata[COORD_WIDTH-2:0];
				REG_STEP_Y:   step_y_q   <= pwdata[COORD_WIDTH-2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_LIMIT:    prdata = PDATA_W'(limit_q);
			REG_X_ORIGIN: prdata = PDATA_W'($signed(x_origin_q));
			REG_Y_ORIGIN: prdata = PDATA_W'($signed(y_origin_q));
			REG_STEP_X:   prdata = PDATA_W'(step_x_q);
			REG_STEP_Y:   prdata = PDATA_W'(step_y_q);
			default:      prdata = '0;
		endcase
	end

	// entry stages: form c
	logic                   valid_s1, valid_s2;
	logic [PRW-1:0]         prodx_s1, prody_s1;
	logic [COORD_WIDTH-1:0] a_s2, b_s2;
	logic signed [CSW-1:0]  a_w, b_w;
	logic                   en_s1, adv_s2, inj;

	assign adv_s2      = !valid_s2 || inj;
	assign en_s1       = !valid_s1 || adv_s2;
	assign pixel_stall = !en_s1;

	assign a_w = $signed(CSW'($signed(x_origin_q))) + $signed(CSW'(prodx_s1));
	assign b_w = $signed(CSW'($signed(y_origin_q))) - $signed(CSW'(prody_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= pixel_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && pixel_valid) begin
			prodx_s1 <= column * step_x_q;
			prody_s1 <= row * step_y_q;
		end
		if (adv_s2 && valid_s1) begin
			a_s2 <= sat_coord(a_w);
			b_s2 <= sat_coord(b_w);
		end
	end

	// iteration loop
	logic valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	ctx_t ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7;
	ctx_t ctx_new, ctx_in, ctx_upd;
	logic [TAG_WIDTH-1:0] tag_q, exp_q;
	logic out_free, emit, slot_free, valid_in;

	logic signed [HW-1:0]     xh, yh;
	logic [H-1:0]             xl, yl;
	logic signed [H:0]        xle, yle;
	logic signed [2*HW-1:0]   xhh_c, yhh_c, xyhh_c, xhh_s4, yhh_s4, xyhh_s4;
	logic signed [HW+H:0]     xhl_c, yhl_c, xyhl_c, xylh_c;
	logic signed [HW+H:0]     xhl_s4, yhl_s4, xyhl_s4, xylh_s4;
	logic [2*H-1:0]           xll_c, yll_c, xyll_c, xll_s4, yll_s4, xyll_s4;
	logic signed [PW-1:0]     xx_c, yy_c, xy_c, xx_s5, yy_s5, xy_s5;
	logic [PW-1:0]            ssq_c, ssq_s6;
	logic signed [PW-1:0]     dif_c, dif_s6, xy_s6;
	logic signed [SW-1:0]     nx_w, ny_w;
	logic                     esc;
	logic [REM_W-1:0]         c255;
	logic [DSW-1:0]           dsub;

	assign out_free  = !result_valid || !result_stall;
	assign emit      = valid_s7 && ctx_s7.done && (ctx_s7.dcnt == DCNT_WIDTH'(DIV_STEPS))
		&& (ctx_s7.tag == exp_q) && out_free;
	assign slot_free = !valid_s7 || emit;
	assign inj       = slot_free && valid_s2;
	assign valid_in  = inj || (valid_s7 && !emit);

	always_comb begin
		ctx_new     = '0;
		ctx_new.tag = tag_q;
		ctx_new.a   = a_s2;
		ctx_new.b   = b_s2;
		ctx_in      = inj ? ctx_new : ctx_s7;
	end

	// partial products of the current iterate
	assign xh  = $signed(ctx_s3.x[ITW-1:H]);
	assign yh  = $signed(ctx_s3.y[ITW-1:H]);
	assign xl  = ctx_s3.x[H-1:0];
	assign yl  = ctx_s3.y[H-1:0];
	assign xle = $signed({1'b0, xl});
	assign yle = $signed({1'b0, yl});

	assign xhh_c  = xh * xh;
	assign yhh_c  = yh * yh;
	assign xyhh_c = xh * yh;
	assign xhl_c  = xh * xle;
	assign yhl_c  = yh * yle;
	assign xyhl_c = xh * yle;
	assign xylh_c = yh * xle;
	assign xll_c  = xl * xl;
	assign yll_c  = yl * yl;
	assign xyll_c = xl * yl;

	// full products
	assign xx_c = (PW'(xhh_s4) << (2 * H)) + (PW'(xhl_s4) << (H + 1)) + PW'(xll_s4);
	assign yy_c = (PW'(yhh_s4) << (2 * H)) + (PW'(yhl_s4) << (H + 1)) + PW'(yll_s4);
	assign xy_c = (PW'(xyhh_s4) << (2 * H)) + ((PW'(xyhl_s4) + PW'(xylh_s4)) << H)
		+ PW'(xyll_s4);

	assign ssq_c = xx_s5 + yy_s5;
	assign dif_c = xx_s5 - yy_s5;

	// escape test, next iterate and one quotient bit per pass
	assign esc  = ssq_s6 > THR;
	assign nx_w = (SW'(dif_s6) >>> FRAC_BITS) + SW'($signed(ctx_s6.a));
	assign ny_w = (SW'(xy_s6) >>> (FRAC_BITS - 1)) + SW'($signed(ctx_s6.b));
	assign c255 = {ctx_s6.cnt, {INTENSITY_WIDTH{1'b0}}} - REM_W'(ctx_s6.cnt);
	assign dsub = {1'b0, ctx_s6.rem} - DSW'({limit_q, {(DIV_STEPS-1){1'b0}}});

	always_comb begin
		ctx_upd = ctx_s6;
		if (ctx_s6.done) begin
			if (ctx_s6.dcnt != DCNT_WIDTH'(DIV_STEPS)) begin
				ctx_upd.dcnt = ctx_s6.dcnt + DCNT_WIDTH'(1);
				if (!dsub[REM_W]) begin
					ctx_upd.rem = {dsub[REM_W-2:0], 1'b0};
					ctx_upd.quo = {ctx_s6.quo[INTENSITY_WIDTH-2:0], 1'b1};
				end else begin
					ctx_upd.rem = {ctx_s6.rem[REM_W-2:0], 1'b0};
					ctx_upd.quo = {ctx_s6.quo[INTENSITY_WIDTH-2:0], 1'b0};
				end
			end
		end else if (esc || (ctx_s6.cnt == limit_q)) begin
			ctx_upd.done = 1'b1;
			ctx_upd.quo  = '0;
			ctx_upd.dcnt = '0;
			if (esc) begin
				ctx_upd.cnt = ctx_s6.cnt - INDEX_WIDTH'(1);
				ctx_upd.rem = c255 - REM_W'(INTENSITY_MAX);
			end else begin
				ctx_upd.rem = c255;
			end
		end else begin
			ctx_upd.x   = sat_iter(nx_w);
			ctx_upd.y   = sat_iter(ny_w);
			ctx_upd.cnt = ctx_s6.cnt + INDEX_WIDTH'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			tag_q    <= '0;
			exp_q    <= '0;
		end else begin
			valid_s3 <= valid_in;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			if (inj) begin
				tag_q <= tag_q + TAG_WIDTH'(1);
			end
			if (emit) begin
				exp_q <= exp_q + TAG_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		ctx_s3  <= ctx_in;
		ctx_s4  <= ctx_s3;
		xhh_s4  <= xhh_c;
		yhh_s4  <= yhh_c;
		xyhh_s4 <= xyhh_c;
		xhl_s4  <= xhl_c;
		yhl_s4  <= yhl_c;
		xyhl_s4 <= xyhl_c;
		xylh_s4 <= xylh_c;
		xll_s4  <= xll_c;
		yll_s4  <= yll_c;
		xyll_s4 <= xyll_c;
		ctx_s5  <= ctx_s4;
		xx_s5   <= xx_c;
		yy_s5   <= yy_c;
		xy_s5   <= xy_c;
		ctx_s6  <= ctx_s5;
		ssq_s6  <= ssq_c;
		dif_s6  <= dif_c;
		xy_s6   <= xy_s5;
		ctx_s7  <= ctx_upd;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			iterations <= ctx_s7.cnt;
			intensity  <= (limit_q == '0) ? '0 : ctx_s7.quo;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(TAG_WIDTH'(tag_q - exp_q) <= TAG_WIDTH'(RING_STAGES)))
		else $error("more requests in flight than loop slots");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s3 || valid_s4 || valid_s5 || valid_s6 || valid_s7) |-> (tag_q == exp_q))
		else $error("empty loop with outstanding tags");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (iterations == limit_q) && (limit_q != '0))
		|-> (intensity == INTENSITY_WIDTH'(INTENSITY_MAX)))
		else $error("full count without full intensity");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (iterations <= limit_q))
		else $error("iteration count above limit");

endmodule
